FILE: src/ecq_pkg.sv
package ecq_pkg;

    // widths fixed by the item fields
    localparam int TYPE_BITS = 4;
    localparam int PAY_BITS  = 32;
    localparam int CNT_BITS  = 6;
    localparam int MASK_BITS = 16;

    // request codes carried on the input tuser
    localparam logic REQ_POST  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // result kinds carried on the output tuser
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_RELEVANT = 2'd0;
    localparam logic [1:0] CFG_COALESCE = 2'd1;
    localparam logic [1:0] CFG_RENDER   = 2'd2;

    // one stored event
    typedef struct packed {
        logic [TYPE_BITS-1:0]       etype;
        logic signed [PAY_BITS-1:0] payload;
    } t_slot;

    // one result item
    typedef struct packed {
        logic                       kind;
        logic [TYPE_BITS-1:0]       etype;
        logic signed [PAY_BITS-1:0] payload;
        logic                       accepted;
        logic [CNT_BITS-1:0]        pending;
        logic                       last;
    } t_result;

    // control from the sequencer to the per-type table
    typedef struct packed {
        logic                 wr_en;
        logic                 clr;
        logic [TYPE_BITS-1:0] wr_type;
    } t_tbl_ctl;

endpackage

FILE: src/event_coalescing_queue.sv
// channel   direction  handshake                        payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser req_type, tdata event fields
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tuser kind, tdata result fields, tlast
// cfg       in         i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// a post's acknowledgement sits in the output register the next cycle
// and a new post is taken every cycle while the output register drains
// with rendering on, a drain of a nonempty queue walks through the slot memory and reads one
// slot per cycle on its single read port while the output is free; the registered read data
// then goes through the keep decision, and the final held event is released when the walk ends
// no input is taken during a drain walk; a stalled output stalls the walk
// reset is synchronous: queue empty, type table invalid, registers at their reset values
module event_coalescing_queue #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TYPE_COUNT  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // event_type[3:0], payload[35:4], zero[39:36]
    input  logic        i_s_axis_tuser,   // req_type[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // out_type[3:0], out_payload[35:4], accepted[36],
                                          // pending_count[42:37], zero[47:43]
    output logic        o_m_axis_tuser,   // kind[0]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    // configuration registers
    logic [ecq_pkg::MASK_BITS-1:0] r_relevant;
    logic [ecq_pkg::MASK_BITS-1:0] r_coalesce;
    logic                          r_render;

    // control state
    logic              r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_dv;
    logic [ADDR_W-1:0] r_dslot;
    logic              r_hold_vld;
    ecq_pkg::t_slot    r_hold;
    logic              r_out_vld;
    ecq_pkg::t_result  r_out;

    logic                          in_acc;
    logic                          out_free;
    logic [ecq_pkg::TYPE_BITS-1:0] in_type;
    logic [ecq_pkg::PAY_BITS-1:0]  in_pay;
    logic                          is_post;
    logic                          is_drain;
    logic                          relevant;
    logic                          store;
    logic                          drain_step;
    logic                          rd_en;
    logic                          walk_done;
    logic                          coal;
    logic                          is_latest;
    logic                          keep;
    logic                          push_held;
    ecq_pkg::t_slot                wr_data;
    ecq_pkg::t_slot                rd_data;
    ecq_pkg::t_tbl_ctl             tbl_ctl;
    logic [CNT_W-1:0]              fill_inc;

    assign in_type  = i_s_axis_tdata[3:0];
    assign in_pay   = i_s_axis_tdata[35:4];
    assign out_free = !r_out_vld || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_post         = in_acc && (i_s_axis_tuser == ecq_pkg::REQ_POST);
    assign is_drain        = in_acc && (i_s_axis_tuser == ecq_pkg::REQ_DRAIN);

    // post filter and room check
    assign relevant = (32'(in_type) < TYPE_COUNT) && r_relevant[in_type];
    assign store    = is_post && relevant && (r_fill < CNT_W'(QUEUE_DEPTH));
    assign fill_inc = r_fill + CNT_W'(1);

    // drain walk: issue stage and data stage advance together
    assign drain_step = (r_state == S_DRAIN) && out_free;
    assign rd_en      = drain_step && (r_rd_idx < r_fill);
    assign walk_done  = drain_step && (r_rd_idx == r_fill) && !r_dv;

    // coalescing decision on the slot just read
    assign coal      = (32'(rd_data.etype) < TYPE_COUNT) && r_coalesce[rd_data.etype];
    assign keep      = !coal || is_latest;
    assign push_held = drain_step && r_dv && keep && r_hold_vld;

    assign wr_data.etype   = in_type;
    assign wr_data.payload = in_pay;

    assign tbl_ctl.wr_en   = store;
    assign tbl_ctl.wr_type = in_type;
    assign tbl_ctl.clr     = walk_done || (is_drain && !r_render);

    ecq_slot_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (store),
        .i_wr_addr (r_fill[ADDR_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    ecq_type_table #(
        .TYPE_COUNT (TYPE_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_tbl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tbl_ctl),
        .i_wr_slot   (r_fill[ADDR_W-1:0]),
        .i_rd_type   (rd_data.etype),
        .i_rd_slot   (r_dslot),
        .o_is_latest (is_latest)
    );

    // configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relevant <= '1;
            r_coalesce <= '0;
            r_render   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ecq_pkg::CFG_RELEVANT: r_relevant <= i_cfg_data;
                ecq_pkg::CFG_COALESCE: r_coalesce <= i_cfg_data;
                ecq_pkg::CFG_RENDER:   r_render   <= i_cfg_data[0];
                default:               ;
            endcase
        end
    end

    // next state and fill count
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        case (r_state)
            S_IDLE: begin
                if (store) begin
                    n_fill = fill_inc;
                end else if (is_drain) begin
                    if (!r_render) begin
                        n_fill = '0;
                    end else if (r_fill != '0) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (walk_done) begin
                    n_state = S_IDLE;
                    n_fill  = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // read address walk and data-valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_dv     <= 1'b0;
        end else if (is_drain) begin
            r_rd_idx <= '0;
            r_dv     <= 1'b0;
        end else if (drain_step) begin
            r_dv <= rd_en;
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_dslot <= r_rd_idx[ADDR_W-1:0];
        end
    end

    // one kept event is held back so the final one can carry tlast
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
        end else if (walk_done) begin
            r_hold_vld <= 1'b0;
        end else if (drain_step && r_dv && keep) begin
            r_hold_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_step && r_dv && keep) begin
            r_hold <= rd_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (is_post || push_held || (walk_done && r_hold_vld)) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_post) begin
            r_out.kind     <= ecq_pkg::KIND_ACK;
            r_out.etype    <= in_type;
            r_out.payload  <= in_pay;
            r_out.accepted <= store;
            r_out.pending  <= ecq_pkg::CNT_BITS'(store ? fill_inc : r_fill);
            r_out.last     <= 1'b1;
        end else if (push_held || (walk_done && r_hold_vld)) begin
            r_out.kind     <= ecq_pkg::KIND_EVENT;
            r_out.etype    <= r_hold.etype;
            r_out.payload  <= r_hold.payload;
            r_out.accepted <= 1'b0;
            r_out.pending  <= '0;
            r_out.last     <= walk_done;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {5'b0, r_out.pending, r_out.accepted, r_out.payload, r_out.etype};

    // fill count never passes the queue depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    // the walk never reads past the stored events
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_rd_idx <= r_fill))
        else $error("drain read index beyond fill count");

    // a finished walk leaves the queue empty
    a_walk_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_done |=> (r_fill == '0) && (r_state == S_IDLE))
        else $error("queue not empty after drain");

    // no read data or held event survives outside a walk
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_dv && !r_hold_vld))
        else $error("walk state left over in idle");

    // the final event of a walk carries tlast
    a_walk_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (walk_done && r_hold_vld) |=> (o_m_axis_tvalid && o_m_axis_tlast))
        else $error("final drained event without tlast");

endmodule

FILE: src/ecq_slot_mem.sv
module ecq_slot_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  ecq_pkg::t_slot        i_wr_data,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output ecq_pkg::t_slot        o_rd_data
);

    ecq_pkg::t_slot r_mem [DEPTH];
    ecq_pkg::t_slot r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rdata;

endmodule

FILE: src/ecq_type_table.sv
module ecq_type_table #(
    parameter int TYPE_COUNT = 16,
    parameter int ADDR_W     = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ecq_pkg::t_tbl_ctl                 i_ctl,
    input  logic [ADDR_W-1:0]                 i_wr_slot,
    input  logic [ecq_pkg::TYPE_BITS-1:0]     i_rd_type,
    input  logic [ADDR_W-1:0]                 i_rd_slot,
    output logic                              o_is_latest
);

    localparam int TYPE_W = $clog2(TYPE_COUNT);

    logic [TYPE_COUNT-1:0] r_valid;
    logic [ADDR_W-1:0]     r_slot [TYPE_COUNT];
    logic [TYPE_W-1:0]     wr_idx;
    logic [TYPE_W-1:0]     rd_idx;
    logic                  rd_in_range;

    assign wr_idx      = TYPE_W'(i_ctl.wr_type);
    assign rd_idx      = TYPE_W'(i_rd_type);
    assign rd_in_range = 32'(i_rd_type) < TYPE_COUNT;

    // valid bit per type, cleared at once by a drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    // slot of the newest occurrence
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_slot[wr_idx] <= i_wr_slot;
        end
    end

    assign o_is_latest = rd_in_range && r_valid[rd_idx] && (r_slot[rd_idx] == i_rd_slot);

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int QDEPTH = 32;
    localparam int NTYPES = 16;
    localparam int COOLDOWN = 50;

    // one request on the input stream
    typedef struct {
        logic                                req;
        logic [ecq_pkg::TYPE_BITS-1:0]       etype;
        logic signed [ecq_pkg::PAY_BITS-1:0] payload;
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        s_valid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_ready = 1'b1;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        o_cfg_ready;

    event_coalescing_queue u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // mirror of the queue state and registers
    logic [ecq_pkg::MASK_BITS-1:0]       mdl_relevant = 16'hFFFF;
    logic [ecq_pkg::MASK_BITS-1:0]       mdl_coalesce = '0;
    logic                                mdl_render = 1'b0;
    logic [ecq_pkg::TYPE_BITS-1:0]       mdl_slot_type [QDEPTH];
    logic signed [ecq_pkg::PAY_BITS-1:0] mdl_slot_pay [QDEPTH];
    int                                  mdl_fill = 0;
    int                                  mdl_newest_slot [NTYPES];
    logic [NTYPES-1:0]                   mdl_newest_valid = '0;

    t_item              request_fifo[$];
    ecq_pkg::t_result   due_results[$];
    int                 n_queued = 0;
    int                 n_accepted = 0;
    int                 n_mismatch = 0;
    bit                 quiet = 1'b0;

    // expected results of one accepted request, appended to due_results
    task automatic predict_results(input t_item it);
        ecq_pkg::t_result r;
        ecq_pkg::t_result delivered[$];
        int      i;
        logic [ecq_pkg::TYPE_BITS-1:0] t;
        if (it.req == ecq_pkg::REQ_POST) begin
            r.accepted = 1'b0;
            if (mdl_relevant[it.etype] && mdl_fill < QDEPTH) begin
                mdl_slot_type[mdl_fill] = it.etype;
                mdl_slot_pay[mdl_fill] = it.payload;
                mdl_newest_slot[it.etype] = mdl_fill;
                mdl_newest_valid[it.etype] = 1'b1;
                mdl_fill++;
                r.accepted = 1'b1;
            end
            r.kind = ecq_pkg::KIND_ACK;
            r.etype = it.etype;
            r.payload = it.payload;
            r.pending = ecq_pkg::CNT_BITS'(mdl_fill);
            r.last = 1'b1;
            due_results.insert(due_results.size(), r);
        end else if (mdl_fill != 0) begin
            if (mdl_render) begin
                for (i = 0; i < mdl_fill; i++) begin
                    t = mdl_slot_type[i];
                    // coalescible type: only its newest slot goes out
                    if (mdl_coalesce[t] && mdl_newest_valid[t] && mdl_newest_slot[t] != i)
                        continue;
                    r.kind = ecq_pkg::KIND_EVENT;
                    r.etype = t;
                    r.payload = mdl_slot_pay[i];
                    r.accepted = 1'b0;
                    r.pending = '0;
                    r.last = 1'b0;
                    delivered.insert(delivered.size(), r);
                end
                if (delivered.size() > 0)
                    delivered[delivered.size() - 1].last = 1'b1;
                foreach (delivered[j])
                    due_results.insert(due_results.size(), delivered[j]);
            end
            mdl_fill = 0;
            mdl_newest_valid = '0;
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", fname, want, got);
            n_mismatch++;
        end
    endtask

    // input stream driver
    always @(posedge i_clk) begin : drive_proc
        logic nxt_valid;
        static int gap_left = 0;
        static t_item cur_item = '{ecq_pkg::REQ_POST, '0, '0};
        nxt_valid = s_valid;
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready) begin
                predict_results(cur_item);
                n_accepted++;
                nxt_valid = 1'b0;
                if (!quiet && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 4);
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_fifo.size() > 0) begin
                    cur_item = request_fifo.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        s_valid <= nxt_valid;
        s_tdata <= {4'b0, cur_item.payload, cur_item.etype};
        s_tuser <= cur_item.req;
    end

    // output stream monitor with random back-pressure
    always @(posedge i_clk) begin : watch_proc
        ecq_pkg::t_result want;
        static int stall_left = 0;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result transaction with nothing expected: type %0h payload %0h",
                           o_m_axis_tdata[3:0], o_m_axis_tdata[35:4]);
                    n_mismatch++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, o_m_axis_tuser);
                    check_field("out_type", want.etype, o_m_axis_tdata[3:0]);
                    check_field("out_payload", want.payload, o_m_axis_tdata[35:4]);
                    check_field("accepted", want.accepted, o_m_axis_tdata[36]);
                    check_field("pending_count", want.pending, o_m_axis_tdata[42:37]);
                    check_field("last", want.last, o_m_axis_tlast);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic add_item(input logic req, input logic [ecq_pkg::TYPE_BITS-1:0] t,
                            input logic [ecq_pkg::PAY_BITS-1:0] p);
        t_item it;
        it.req = req;
        it.etype = t;
        it.payload = p;
        request_fifo.insert(request_fifo.size(), it);
        n_queued++;
    endtask

    // one register write transaction, mirrored into the model once taken
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            ecq_pkg::CFG_RELEVANT: mdl_relevant = val;
            ecq_pkg::CFG_COALESCE: mdl_coalesce = val;
            ecq_pkg::CFG_RENDER:   mdl_render = val[0];
            default: ;
        endcase
    endtask

    // wait until every request is taken and every result has come back
    task automatic settle();
        while (n_accepted != n_queued || due_results.size() != 0)
            @(posedge i_clk);
        repeat (COOLDOWN) @(posedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        int k;
        int n_posts;
        int random_start;
        int phase_start;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty drain, extreme payloads, drain with no consumer
        add_item(ecq_pkg::REQ_DRAIN, 4'h0, 32'h0);
        add_item(ecq_pkg::REQ_POST, 4'h0, 32'h8000_0000);
        add_item(ecq_pkg::REQ_POST, 4'hF, 32'h7FFF_FFFF);
        add_item(ecq_pkg::REQ_DRAIN, 4'hF, 32'hFFFF_FFFF);
        settle();

        // type 15 filtered, types 0 and 15 coalescible, consumer attached
        write_reg(ecq_pkg::CFG_RELEVANT, 16'h7FFF);
        write_reg(ecq_pkg::CFG_COALESCE, 16'h8001);
        write_reg(ecq_pkg::CFG_RENDER, 16'h0001);
        add_item(ecq_pkg::REQ_POST, 4'h0, 32'h0);
        add_item(ecq_pkg::REQ_POST, 4'hF, 32'hFFFF_FFFF);
        add_item(ecq_pkg::REQ_POST, 4'h1, 32'h5);
        add_item(ecq_pkg::REQ_POST, 4'h0, 32'h7);
        add_item(ecq_pkg::REQ_POST, 4'h2, 32'h5A5A_A5A5);
        add_item(ecq_pkg::REQ_POST, 4'hF, 32'h1234_5678);
        add_item(ecq_pkg::REQ_DRAIN, 4'h0, 32'h0);
        add_item(ecq_pkg::REQ_DRAIN, 4'h5, 32'h0);
        add_item(ecq_pkg::REQ_POST, 4'h0, 32'h7FFF_FFFF);
        add_item(ecq_pkg::REQ_POST, 4'h0, 32'h8000_0000);
        add_item(ecq_pkg::REQ_POST, 4'h3, 32'h1);
        add_item(ecq_pkg::REQ_DRAIN, 4'hA, 32'hA5A5_5A5A);
        settle();

        // nothing relevant, everything coalescible, out-of-range register index
        write_reg(ecq_pkg::CFG_RELEVANT, 16'h0000);
        write_reg(ecq_pkg::CFG_COALESCE, 16'hFFFF);
        write_reg(2'd3, 16'hFFFF);
        add_item(ecq_pkg::REQ_POST, 4'h3, 32'hDEAD_BEEF);
        add_item(ecq_pkg::REQ_POST, 4'h9, 32'h0BAD_F00D);
        add_item(ecq_pkg::REQ_DRAIN, 4'h0, 32'h0);
        settle();

        // queue full: overfill then a drain that delivers every slot
        write_reg(ecq_pkg::CFG_RELEVANT, 16'hFFFF);
        write_reg(ecq_pkg::CFG_COALESCE, 16'h0000);
        write_reg(ecq_pkg::CFG_RENDER, 16'h0001);
        random_start = n_queued;
        for (k = 0; k < QDEPTH + 2; k++)
            add_item(ecq_pkg::REQ_POST, 4'($urandom_range(0, 15)), $urandom);
        add_item(ecq_pkg::REQ_DRAIN, 4'($urandom_range(0, 15)), $urandom);
        settle();

        // random phases of post bursts closed by drains, with some noise
        while (n_queued - random_start < 330) begin
            if (n_queued - random_start >= 280)
                quiet = 1'b1;
            case ($urandom_range(0, 5))
                0: write_reg(ecq_pkg::CFG_RELEVANT, 16'h0000);
                1, 2: write_reg(ecq_pkg::CFG_RELEVANT, 16'hFFFF);
                default: write_reg(ecq_pkg::CFG_RELEVANT, 16'($urandom));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(ecq_pkg::CFG_COALESCE, 16'h0000);
                1: write_reg(ecq_pkg::CFG_COALESCE, 16'hFFFF);
                default: write_reg(ecq_pkg::CFG_COALESCE, 16'($urandom));
            endcase
            write_reg(ecq_pkg::CFG_RENDER, {15'b0, $urandom_range(0, 3) != 0});
            phase_start = n_queued;
            while (n_queued - phase_start < 50 && n_queued - random_start < 330) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom);
                end else begin
                    n_posts = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 36)
                                                          : $urandom_range(0, 8);
                    // a narrow type range makes repeats, and so coalescing, likely
                    for (k = 0; k < n_posts; k++)
                        add_item(ecq_pkg::REQ_POST,
                                 ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                                             : 4'($urandom_range(0, 15)),
                                 $urandom);
                    if ($urandom_range(0, 9) != 0)
                        add_item(ecq_pkg::REQ_DRAIN, 4'($urandom_range(0, 15)), $urandom);
                end
            end
            settle();
        end

        if (n_mismatch == 0 && due_results.size() == 0) begin
            $display("event_coalescing_queue: match");
        end else begin
            $display("event_coalescing_queue: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin
        #3600000;
        $display("event_coalescing_queue: mismatch");
        $finish;
    end

endmodule
